[rtl/char_lcd_parallel_write_sequencer_top_macros.svh]
// assertion helpers used by the sequencer core
`ifndef CHAR_LCD_PARALLEL_WRITE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_PARALLEL_WRITE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CLWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CLWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/clws_pkg.sv]
`default_nettype none

package clws_pkg;

  // register and field widths
  localparam int unsigned REG_W       = 16;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned POS_W       = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_POWER_ON   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EN_HIGH    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_WAIT  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_WAIT = 8'd3;

  // register reset values
  localparam logic [REG_W-1:0] POWER_ON_RST   = 16'd30;
  localparam logic [REG_W-1:0] EN_HIGH_RST    = 16'd1;
  localparam logic [REG_W-1:0] LONG_WAIT_RST  = 16'd2;
  localparam logic [REG_W-1:0] SHORT_WAIT_RST = 16'd1;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CMD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;

  // init list length, position once done, long-wait command limit
  localparam logic [POS_W-1:0]  INIT_DONE  = 3'd7;
  localparam logic [BYTE_W-1:0] LONG_LIMIT = 8'd4;

  typedef enum logic [4:0] {
    PH_POWER  = 5'b00001,
    PH_ENHIGH = 5'b00010,
    PH_POST   = 5'b00100,
    PH_EXTRA  = 5'b01000,
    PH_READY  = 5'b10000
  } phase_t;

  // one result of the sequencer
  typedef struct packed {
    logic              pin_rs;
    logic              pin_rw;
    logic              pin_en;
    logic [BYTE_W-1:0] pin_bus;
    logic              ready_res;
    logic              rejected;
  } result_t;

  // init command bytes
  function automatic logic [BYTE_W-1:0] init_byte(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      3'd0:    b = 8'h30;
      3'd1:    b = 8'h30;
      3'd2:    b = 8'h30;
      3'd3:    b = 8'h38;
      3'd4:    b = 8'h06;
      3'd5:    b = 8'h01;
      3'd6:    b = 8'h0F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // extra ticks after an init entry
  function automatic logic [REG_W-1:0] init_extra(input logic [POS_W-1:0] pos);
    logic [REG_W-1:0] e;
    case (pos)
      3'd0:    e = 16'd10;
      3'd1:    e = 16'd1;
      default: e = 16'd0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

[rtl/clws_core.sv]
`default_nettype none
`include "char_lcd_parallel_write_sequencer_top_macros.svh"

module clws_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_fire,
  input  wire logic [clws_pkg::KIND_W-1:0]        kind,
  input  wire logic [clws_pkg::BYTE_W-1:0]        byte_value,
  input  wire logic                               cfg_we,
  input  wire logic [clws_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [clws_pkg::REG_W-1:0]         cfg_data,
  output clws_pkg::result_t                       res
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > clws_pkg::REG_W) ? COUNT_WIDTH : clws_pkg::REG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [clws_pkg::REG_W-1:0]  power_on_ticks, en_high_ticks;
  logic [clws_pkg::REG_W-1:0]  long_wait_ticks, short_wait_ticks;

  clws_pkg::phase_t            phase, phase_next;
  logic [COUNT_WIDTH-1:0]      tick_counter, tick_counter_next;
  logic [clws_pkg::POS_W-1:0]  init_position, init_position_next;
  logic [clws_pkg::BYTE_W-1:0] latched_byte, latched_byte_next;
  logic                        latched_rs, latched_rs_next;
  logic                        latched_long, latched_long_next;

  logic [clws_pkg::REG_W-1:0]  target;
  logic [CMP_W-1:0]            target_ext, target_clamp;
  logic [COUNT_WIDTH-1:0]      cnt_inc;
  logic                        reach;
  logic                        is_write;
  logic                        rejected;
  logic [clws_pkg::POS_W-1:0]  pos_inc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      power_on_ticks   <= clws_pkg::POWER_ON_RST;
      en_high_ticks    <= clws_pkg::EN_HIGH_RST;
      long_wait_ticks  <= clws_pkg::LONG_WAIT_RST;
      short_wait_ticks <= clws_pkg::SHORT_WAIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        clws_pkg::CFG_POWER_ON:   power_on_ticks   <= cfg_data;
        clws_pkg::CFG_EN_HIGH:    en_high_ticks    <= cfg_data;
        clws_pkg::CFG_LONG_WAIT:  long_wait_ticks  <= cfg_data;
        clws_pkg::CFG_SHORT_WAIT: short_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // target of the current waiting phase
  always_comb begin
    case (phase)
      clws_pkg::PH_POWER:  target = power_on_ticks;
      clws_pkg::PH_ENHIGH: target = en_high_ticks;
      clws_pkg::PH_POST:   target = latched_long ? long_wait_ticks : short_wait_ticks;
      clws_pkg::PH_EXTRA:  target = clws_pkg::init_extra(init_position);
      default:             target = '0;
    endcase
  end

  // saturating increment and compare against the clamped target
  assign target_ext   = CMP_W'(target);
  assign target_clamp = (target_ext > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX) : target_ext;
  assign cnt_inc      = (tick_counter == CNT_MAX) ? tick_counter
                                                  : tick_counter + 1'b1;
  assign reach        = (CMP_W'(cnt_inc) >= target_clamp);
  assign pos_inc      = init_position + 1'b1;

  assign is_write = (kind == clws_pkg::KIND_CMD) || (kind == clws_pkg::KIND_DATA);
  assign rejected = is_write && (phase != clws_pkg::PH_READY);

  // next state for one request
  always_comb begin
    phase_next         = phase;
    tick_counter_next  = tick_counter;
    init_position_next = init_position;
    latched_byte_next  = latched_byte;
    latched_rs_next    = latched_rs;
    latched_long_next  = latched_long;

    if (kind == clws_pkg::KIND_TICK) begin
      case (phase)
        clws_pkg::PH_POWER: begin
          tick_counter_next = reach ? '0 : cnt_inc;
          if (reach) begin
            init_position_next = '0;
            latched_byte_next  = clws_pkg::init_byte('0);
            latched_rs_next    = 1'b0;
            latched_long_next  = (clws_pkg::init_byte('0) < clws_pkg::LONG_LIMIT);
            phase_next         = clws_pkg::PH_ENHIGH;
          end
        end
        clws_pkg::PH_ENHIGH: begin
          tick_counter_next = reach ? '0 : cnt_inc;
          if (reach) phase_next = clws_pkg::PH_POST;
        end
        clws_pkg::PH_POST: begin
          tick_counter_next = reach ? '0 : cnt_inc;
          if (reach) begin
            if (init_position == clws_pkg::INIT_DONE) begin
              phase_next = clws_pkg::PH_READY;
            end else if (clws_pkg::init_extra(init_position) != '0) begin
              phase_next = clws_pkg::PH_EXTRA;
            end else begin
              init_position_next = pos_inc;
              if (pos_inc != clws_pkg::INIT_DONE) begin
                latched_byte_next = clws_pkg::init_byte(pos_inc);
                latched_rs_next   = 1'b0;
                latched_long_next = (clws_pkg::init_byte(pos_inc) < clws_pkg::LONG_LIMIT);
                phase_next        = clws_pkg::PH_ENHIGH;
              end else begin
                phase_next = clws_pkg::PH_READY;
              end
            end
          end
        end
        clws_pkg::PH_EXTRA: begin
          if (init_position == clws_pkg::INIT_DONE) begin
            phase_next = clws_pkg::PH_READY;
          end else begin
            tick_counter_next = reach ? '0 : cnt_inc;
            if (reach) begin
              init_position_next = pos_inc;
              if (pos_inc != clws_pkg::INIT_DONE) begin
                latched_byte_next = clws_pkg::init_byte(pos_inc);
                latched_rs_next   = 1'b0;
                latched_long_next = (clws_pkg::init_byte(pos_inc) < clws_pkg::LONG_LIMIT);
                phase_next        = clws_pkg::PH_ENHIGH;
              end else begin
                phase_next = clws_pkg::PH_READY;
              end
            end
          end
        end
        default: ;
      endcase
    end else if (is_write && (phase == clws_pkg::PH_READY)) begin
      // host write starts a strobe right away
      latched_byte_next = byte_value;
      latched_rs_next   = (kind == clws_pkg::KIND_DATA);
      latched_long_next = (kind == clws_pkg::KIND_CMD) && (byte_value < clws_pkg::LONG_LIMIT);
      phase_next        = clws_pkg::PH_ENHIGH;
      tick_counter_next = '0;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= clws_pkg::PH_POWER;
      tick_counter  <= '0;
      init_position <= '0;
      latched_byte  <= '0;
      latched_rs    <= 1'b0;
      latched_long  <= 1'b0;
    end else if (in_fire) begin
      phase         <= phase_next;
      tick_counter  <= tick_counter_next;
      init_position <= init_position_next;
      latched_byte  <= latched_byte_next;
      latched_rs    <= latched_rs_next;
      latched_long  <= latched_long_next;
    end
  end

  // result seen after this request
  always_comb begin
    res.pin_rs    = latched_rs_next;
    res.pin_rw    = 1'b0;
    res.pin_en    = (phase_next == clws_pkg::PH_ENHIGH);
    res.pin_bus   = latched_byte_next;
    res.ready_res = (phase_next == clws_pkg::PH_READY);
    res.rejected  = rejected;
  end

  // checks
  `CLWS_ASSERT_NEXT(a_write_starts_strobe, in_fire && is_write && phase == clws_pkg::PH_READY, phase == clws_pkg::PH_ENHIGH && tick_counter == '0, "accepted write did not raise the strobe")
  `CLWS_ASSERT_NEXT(a_busy_write_no_change, in_fire && rejected, $stable(phase) && $stable(latched_byte) && $stable(tick_counter), "dropped write changed state")
  `CLWS_ASSERT_NOW(a_done_no_init_phase, init_position == clws_pkg::INIT_DONE, phase != clws_pkg::PH_POWER && phase != clws_pkg::PH_EXTRA, "init phase seen after init list done")
  `CLWS_ASSERT_NEXT(a_idle_holds_state, !in_fire, $stable(phase) && $stable(tick_counter) && $stable(init_position), "state moved without a request")

endmodule

`default_nettype wire

[rtl/clws_out_reg.sv]
`default_nettype none

module clws_out_reg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire clws_pkg::result_t res_in,
  input  wire logic        out_stall,
  output logic             out_valid,
  output clws_pkg::result_t res_out
);

  // valid flag: set on load, held while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

[rtl/char_lcd_parallel_write_sequencer_top.sv]
// a request accepted at one edge has its result valid from the next cycle
// throughput: one request per cycle while the result receiver does not stall, set by the single result register
// a new request is taken whenever the result register is empty or being drained
// reset (rst, synchronous, active high): power-on wait phase, counters and latches
// cleared, registers to their defaults, no result pending
`default_nettype none

module char_lcd_parallel_write_sequencer_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [clws_pkg::KIND_W-1:0]        kind,
  input  wire logic [clws_pkg::BYTE_W-1:0]        byte_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    pin_rs,
  output logic                                    pin_rw,
  output logic                                    pin_en,
  output logic [clws_pkg::BYTE_W-1:0]             pin_bus,
  output logic                                    ready_res,
  output logic                                    rejected,
  input  wire logic                               cfg_we,
  input  wire logic [clws_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [clws_pkg::REG_W-1:0]         cfg_data
);

  logic              in_fire;
  clws_pkg::result_t res_next;
  clws_pkg::result_t res_q;

  // request taken when the result slot frees up
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  clws_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .kind       (kind),
    .byte_value (byte_value),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res        (res_next)
  );

  clws_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .res_in    (res_next),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  // result fields to pins
  assign pin_rs    = res_q.pin_rs;
  assign pin_rw    = res_q.pin_rw;
  assign pin_en    = res_q.pin_en;
  assign pin_bus   = res_q.pin_bus;
  assign ready_res = res_q.ready_res;
  assign rejected  = res_q.rejected;

endmodule

`default_nettype wire

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_WIDTH) - 1;
  localparam int unsigned INIT_LEN = 7;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam logic [clws_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [clws_pkg::CFG_INDEX_W-1:0] CFG_BAD_TOP = 8'hFF;
  localparam logic [clws_pkg::CFG_INDEX_W-1:0] CFG_BAD_MSB = 8'h80;

  // power-up command list, entry 0 first
  localparam logic [6:0][clws_pkg::BYTE_W-1:0] INIT_CMDS =
    {8'h0F, 8'h01, 8'h06, 8'h38, 8'h30, 8'h30, 8'h30};
  localparam logic [6:0][3:0] INIT_EXTRA =
    {4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd10};

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [clws_pkg::KIND_W-1:0] kind;
  logic [clws_pkg::BYTE_W-1:0] byte_value;
  logic out_valid;
  logic out_stall;
  logic pin_rs;
  logic pin_rw;
  logic pin_en;
  logic [clws_pkg::BYTE_W-1:0] pin_bus;
  logic ready_res;
  logic rejected;
  logic cfg_we;
  logic [clws_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [clws_pkg::REG_W-1:0] cfg_data;

  char_lcd_parallel_write_sequencer_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .byte_value (byte_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pin_rs     (pin_rs),
    .pin_rw     (pin_rw),
    .pin_en     (pin_en),
    .pin_bus    (pin_bus),
    .ready_res  (ready_res),
    .rejected   (rejected),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // sequencer shadow state and registers
  clws_pkg::phase_t seq_ph = clws_pkg::PH_POWER;
  longint unsigned tick_cnt = 0;
  int unsigned init_pos = 0;
  logic [clws_pkg::BYTE_W-1:0] lat_byte = '0;
  logic lat_rs = 1'b0;
  logic lat_long = 1'b0;
  longint unsigned pwr_ticks = clws_pkg::POWER_ON_RST;
  longint unsigned en_ticks = clws_pkg::EN_HIGH_RST;
  longint unsigned long_ticks = clws_pkg::LONG_WAIT_RST;
  longint unsigned short_ticks = clws_pkg::SHORT_WAIT_RST;

  clws_pkg::result_t pin_expect_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  int unsigned idle_cycles = 0;

  // one tick of a waiting phase, true when the target is reached
  function automatic bit count_tick(longint unsigned target);
    if (target > CNT_MAX) target = CNT_MAX;
    if (tick_cnt < CNT_MAX) tick_cnt++;
    if (tick_cnt >= target) begin
      tick_cnt = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void start_write(logic [clws_pkg::BYTE_W-1:0] b, logic rs);
    lat_byte = b;
    lat_rs = rs;
    lat_long = !rs && (b < clws_pkg::LONG_LIMIT);
    seq_ph = clws_pkg::PH_ENHIGH;
    tick_cnt = 0;
  endfunction

  function automatic void next_entry();
    init_pos++;
    if (init_pos < INIT_LEN) begin
      start_write(INIT_CMDS[init_pos], 1'b0);
    end else begin
      init_pos = INIT_LEN;
      seq_ph = clws_pkg::PH_READY;
    end
  endfunction

  function automatic void advance_tick();
    case (seq_ph)
      clws_pkg::PH_POWER: begin
        if (count_tick(pwr_ticks)) begin
          init_pos = 0;
          start_write(INIT_CMDS[0], 1'b0);
        end
      end
      clws_pkg::PH_ENHIGH: begin
        if (count_tick(en_ticks)) seq_ph = clws_pkg::PH_POST;
      end
      clws_pkg::PH_POST: begin
        if (count_tick(lat_long ? long_ticks : short_ticks)) begin
          if (init_pos >= INIT_LEN) seq_ph = clws_pkg::PH_READY;
          else if (INIT_EXTRA[init_pos] != 0) seq_ph = clws_pkg::PH_EXTRA;
          else next_entry();
        end
      end
      clws_pkg::PH_EXTRA: begin
        if (init_pos >= INIT_LEN) seq_ph = clws_pkg::PH_READY;
        else if (count_tick(INIT_EXTRA[init_pos])) next_entry();
      end
      default: ;
    endcase
  endfunction

  // pin levels after one request
  function automatic clws_pkg::result_t lcd_pins_after(logic [clws_pkg::KIND_W-1:0] k,
                                                       logic [clws_pkg::BYTE_W-1:0] b);
    clws_pkg::result_t r;
    logic rej;
    rej = 1'b0;
    if (k == clws_pkg::KIND_TICK) begin
      advance_tick();
    end else if (k == clws_pkg::KIND_CMD || k == clws_pkg::KIND_DATA) begin
      if (seq_ph == clws_pkg::PH_READY) start_write(b, k == clws_pkg::KIND_DATA);
      else rej = 1'b1;
    end
    r.pin_rs = lat_rs;
    r.pin_rw = 1'b0;
    r.pin_en = (seq_ph == clws_pkg::PH_ENHIGH);
    r.pin_bus = lat_byte;
    r.ready_res = (seq_ph == clws_pkg::PH_READY);
    r.rejected = rej;
    return r;
  endfunction

  function automatic clws_pkg::result_t pins(bit rs, bit en, logic [clws_pkg::BYTE_W-1:0] bus,
                                             bit rdy, bit rej);
    clws_pkg::result_t r;
    r = {rs, 1'b0, en, bus, rdy, rej};
    return r;
  endfunction

  // request driver, holds the payload until taken
  task automatic send_req(logic [clws_pkg::KIND_W-1:0] k, logic [clws_pkg::BYTE_W-1:0] b,
                          bit typed, clws_pkg::result_t typed_res);
    clws_pkg::result_t pred;
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    byte_value = b;
    do begin
      @(posedge clk);
    end while (in_stall);
    pred = lcd_pins_after(k, b);
    pin_expect_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic idle_in(int unsigned n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 7) == 0) idle_in($urandom_range(1, 12));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pin_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [clws_pkg::CFG_INDEX_W-1:0] idx,
                           logic [clws_pkg::REG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      clws_pkg::CFG_POWER_ON:   pwr_ticks = val;
      clws_pkg::CFG_EN_HIGH:    en_ticks = val;
      clws_pkg::CFG_LONG_WAIT:  long_ticks = val;
      clws_pkg::CFG_SHORT_WAIT: short_ticks = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_cfg(logic [clws_pkg::REG_W-1:0] p, logic [clws_pkg::REG_W-1:0] e,
                           logic [clws_pkg::REG_W-1:0] l, logic [clws_pkg::REG_W-1:0] s);
    write_reg(clws_pkg::CFG_POWER_ON, p);
    write_reg(clws_pkg::CFG_EN_HIGH, e);
    write_reg(clws_pkg::CFG_LONG_WAIT, l);
    write_reg(clws_pkg::CFG_SHORT_WAIT, s);
  endtask

  // random requests, mostly writes when ready and ticks when busy
  task automatic run_random(int n);
    logic [clws_pkg::KIND_W-1:0] k;
    logic [clws_pkg::BYTE_W-1:0] b;
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (seq_ph == clws_pkg::PH_READY)
        k = (roll < 35) ? clws_pkg::KIND_CMD : (roll < 70) ? clws_pkg::KIND_DATA :
            (roll < 95) ? clws_pkg::KIND_TICK : KIND_UNUSED;
      else
        k = (roll < 78) ? clws_pkg::KIND_TICK : (roll < 88) ? clws_pkg::KIND_CMD :
            (roll < 96) ? clws_pkg::KIND_DATA : KIND_UNUSED;
      if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 5));
      else b = 8'($urandom_range(0, 255));
      maybe_gap();
      send_req(k, b, 1'b0, '0);
    end
  endtask

  // result receiver stall bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // compare each taken result against the oldest expectation
  always @(posedge clk) begin
    clws_pkg::result_t got;
    clws_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {pin_rs, pin_rw, pin_en, pin_bus, ready_res, rejected};
      if (pin_expect_q.size() == 0) begin
        $display("%0t: result %0h with no pending request", $time, got);
        errors++;
      end else begin
        want = pin_expect_q.pop_front();
        check_field("pin_rs", want.pin_rs, got.pin_rs);
        check_field("pin_rw", want.pin_rw, got.pin_rw);
        check_field("pin_en", want.pin_en, got.pin_en);
        check_field("pin_bus", want.pin_bus, got.pin_bus);
        check_field("ready_res", want.ready_res, got.ready_res);
        check_field("rejected", want.rejected, got.rejected);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress, %0d results outstanding", $time, pin_expect_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  typedef struct {
    logic [clws_pkg::KIND_W-1:0] k;
    logic [clws_pkg::BYTE_W-1:0] b;
    int reps;
    bit typed;
    clws_pkg::result_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(logic [clws_pkg::KIND_W-1:0] k, logic [clws_pkg::BYTE_W-1:0] b,
                         int reps, bit typed, clws_pkg::result_t res);
    dir_row_t r;
    r.k = k;
    r.b = b;
    r.reps = reps;
    r.typed = typed;
    r.res = res;
    dir_rows.push_back(r);
  endtask

  initial begin
    in_valid = 1'b0;
    kind = clws_pkg::KIND_TICK;
    byte_value = '0;
    cfg_we = 1'b0;
    cfg_index = clws_pkg::CFG_POWER_ON;
    cfg_data = '0;
    rst = 1'b1;

    // directed rows at reset register values
    // writes and the unused kind during the power-on wait
    add_row(clws_pkg::KIND_CMD, 8'hFF, 1, 1, pins(0, 0, 8'h00, 0, 1));
    add_row(clws_pkg::KIND_DATA, 8'h00, 1, 1, pins(0, 0, 8'h00, 0, 1));
    add_row(KIND_UNUSED, 8'hAA, 1, 1, pins(0, 0, 8'h00, 0, 0));
    add_row(clws_pkg::KIND_TICK, 8'h5A, 29, 1, pins(0, 0, 8'h00, 0, 0));
    // first init command strobes
    add_row(clws_pkg::KIND_TICK, 8'h00, 1, 1, pins(0, 1, 8'h30, 0, 0));
    add_row(clws_pkg::KIND_DATA, 8'h41, 1, 1, pins(0, 1, 8'h30, 0, 1));
    add_row(clws_pkg::KIND_TICK, 8'hFF, 1, 1, pins(0, 0, 8'h30, 0, 0));
    add_row(clws_pkg::KIND_TICK, 8'h00, 10, 0, '0);
    add_row(clws_pkg::KIND_TICK, 8'hFF, 14, 0, '0);
    add_row(clws_pkg::KIND_TICK, 8'h00, 1, 1, pins(0, 0, 8'h0F, 1, 0));
    // ready: long-wait command, busy write, data write
    add_row(clws_pkg::KIND_CMD, 8'h00, 1, 1, pins(0, 1, 8'h00, 0, 0));
    add_row(clws_pkg::KIND_CMD, 8'h80, 1, 1, pins(0, 1, 8'h00, 0, 1));
    add_row(clws_pkg::KIND_TICK, 8'hFF, 3, 0, '0);
    add_row(clws_pkg::KIND_DATA, 8'hFF, 1, 1, pins(1, 1, 8'hFF, 0, 0));
    add_row(clws_pkg::KIND_TICK, 8'h00, 2, 0, '0);
    // long wait boundary at command 3 and 4
    add_row(clws_pkg::KIND_CMD, 8'h03, 1, 0, '0);
    add_row(clws_pkg::KIND_TICK, 8'hFF, 3, 0, '0);
    add_row(clws_pkg::KIND_CMD, 8'h04, 1, 0, '0);
    add_row(clws_pkg::KIND_TICK, 8'h00, 2, 0, '0);
    add_row(KIND_UNUSED, 8'h55, 1, 1, pins(0, 0, 8'h04, 1, 0));
    add_row(clws_pkg::KIND_DATA, 8'h00, 1, 0, '0);
    add_row(clws_pkg::KIND_TICK, 8'hFF, 2, 0, '0);
    add_row(clws_pkg::KIND_CMD, 8'hFF, 1, 0, '0);
    add_row(clws_pkg::KIND_TICK, 8'h00, 2, 1, pins(0, 0, 8'hFF, 1, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      for (int r = 0; r < dir_rows[i].reps; r++) begin
        maybe_gap();
        send_req(dir_rows[i].k, dir_rows[i].b, dir_rows[i].typed && (r == dir_rows[i].reps - 1),
                 dir_rows[i].res);
      end
    end
    drain();

    // random phases over several register sets
    apply_cfg(16'd1, 16'd1, 16'd1, 16'd1);
    run_random(180);
    drain();

    // zero registers behave like one, out-of-range indexes ignored
    apply_cfg(16'd0, 16'd0, 16'd0, 16'd0);
    write_reg(CFG_BAD_TOP, 16'hFFFF);
    write_reg(CFG_BAD_MSB, 16'h0000);
    run_random(160);
    drain();

    apply_cfg(16'd7, 16'd3, 16'd9, 16'd2);
    run_random(180);
    drain();

    // maximum targets, block stays busy
    apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(60);
    drain();

    apply_cfg(16'd2, 16'd2, 16'd5, 16'd1);
    run_random(170);
    drain();

    // closing phase at full rate
    quiet = 1'b1;
    apply_cfg(clws_pkg::POWER_ON_RST, clws_pkg::EN_HIGH_RST, clws_pkg::LONG_WAIT_RST,
              clws_pkg::SHORT_WAIT_RST);
    run_random(200);
    drain();
    repeat (4) @(posedge clk);

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/clws_pkg.sv
rtl/clws_core.sv
rtl/clws_out_reg.sv
rtl/char_lcd_parallel_write_sequencer_top.sv
bench/testbench.sv
